// ----- hdl/trd_pkg.sv -----
// shared types and constants for the tga run-length pixel decoder
`timescale 1ns / 1ps
`default_nettype none

package trd_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_RLE_ENABLED   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HAS_ALPHA     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOP_TO_BOTTOM = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_TO_LEFT = 3'd5;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;

    localparam logic [7:0] OPAQUE_ALPHA = 8'hff;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } trd_state_t;

    // controller to datapath
    typedef struct packed {
        logic take_byte;
        logic walk_step;
        logic load_out;
    } trd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic pixel_done;
        logic walk_done;
        logic slot_free;
    } trd_status_t;

endpackage

`default_nettype wire

// ----- hdl/trd_ctrl.sv -----
// controller state machine for the tga run-length pixel decoder
`timescale 1ns / 1ps
`default_nettype none

module trd_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  trd_pkg::trd_status_t status,
    output trd_pkg::trd_cmd_t   cmd
);
    import trd_pkg::*;

    trd_state_t state_reg;
    trd_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && !status.skip) begin
                    cmd.take_byte = 1'b1;
                    if (status.pixel_done) begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                if (status.walk_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.slot_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/trd_dp.sv -----
// datapath: configuration, packet and pixel assembly, position walk and output register
`timescale 1ns / 1ps
`default_nettype none

module trd_dp (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  trd_pkg::trd_cmd_t                  cmd,
    output trd_pkg::trd_status_t               status,
    input  wire                                cfg_wr_en,
    input  wire  [trd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [trd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire  [trd_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [trd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast
);
    import trd_pkg::*;

    // configuration
    logic        rle_en_reg, has_alpha_reg, ttb_reg, rtl_reg;
    logic [15:0] width_reg, height_reg;

    // stream state
    logic        expect_hdr_reg, expect_hdr_next;
    logic [1:0]  bip_reg, bip_next;
    logic [7:0]  pkt_rem_reg, pkt_rem_next;
    logic        pkt_run_reg, pkt_run_next;
    logic [23:0] held_reg, held_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic        done_reg, done_next;

    // pending record
    logic [7:0]  adv_reg, adv_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  red_reg, red_next, green_reg, green_next;
    logic [7:0]  blue_reg, blue_next, alpha_reg, alpha_next;
    logic [15:0] dest_x_reg, dest_x_next, dest_y_reg, dest_y_next;
    logic        last_reg, last_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;

    logic        hdr_byte;
    logic [2:0]  bip_inc, stride;
    logic [7:0]  new_copies;
    logic [15:0] space;
    logic        fits, last_row;
    logic [7:0]  left;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rle_en_reg    <= 1'b0;
            has_alpha_reg <= 1'b0;
            width_reg     <= 16'd1;
            height_reg    <= 16'd1;
            ttb_reg       <= 1'b0;
            rtl_reg       <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RLE_ENABLED:   rle_en_reg    <= cfg_wdata[0];
                CFG_HAS_ALPHA:     has_alpha_reg <= cfg_wdata[0];
                CFG_IMAGE_WIDTH:   width_reg     <= cfg_wdata;
                CFG_IMAGE_HEIGHT:  height_reg    <= cfg_wdata;
                CFG_TOP_TO_BOTTOM: ttb_reg       <= cfg_wdata[0];
                CFG_RIGHT_TO_LEFT: rtl_reg       <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign hdr_byte = rle_en_reg && expect_hdr_reg;
    assign bip_inc  = {1'b0, bip_reg} + 3'd1;
    assign stride   = has_alpha_reg ? 3'd4 : 3'd3;

    // a run with a zero count still paints one pixel
    always_comb begin
        new_copies = 8'd1;
        if (rle_en_reg && pkt_run_reg && pkt_rem_reg != 8'd0) begin
            new_copies = pkt_rem_reg;
        end
    end

    // one row wrap per walk step
    assign space    = width_reg - col_reg;
    assign fits     = {8'd0, adv_reg} < space;
    assign left     = adv_reg - space[7:0];
    assign last_row = row_reg == height_reg - 16'd1;

    always_comb begin
        status.skip       = done_reg || width_reg == 16'd0 || height_reg == 16'd0 ||
                            col_reg >= width_reg || row_reg >= height_reg;
        status.pixel_done = !hdr_byte && bip_inc >= stride;
        status.walk_done  = fits || last_row || left == 8'd0;
        status.slot_free  = !out_valid_reg || m_tready;
    end

    always_comb begin
        expect_hdr_next = expect_hdr_reg;
        bip_next        = bip_reg;
        pkt_rem_next    = pkt_rem_reg;
        pkt_run_next    = pkt_run_reg;
        held_next       = held_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        done_next       = done_reg;
        adv_next        = adv_reg;
        cnt_next        = cnt_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        alpha_next      = alpha_reg;
        dest_x_next     = dest_x_reg;
        dest_y_next     = dest_y_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;

        if (cmd.take_byte) begin
            if (hdr_byte) begin
                pkt_rem_next    = {1'b0, s_tdata[6:0]} + 8'd1;
                pkt_run_next    = s_tdata[7];
                expect_hdr_next = 1'b0;
                bip_next        = 2'd0;
                held_next       = '0;
            end else if (!status.pixel_done) begin
                case (bip_reg)
                    2'd0:    held_next[7:0]   = s_tdata;
                    2'd1:    held_next[15:8]  = s_tdata;
                    2'd2:    held_next[23:16] = s_tdata;
                    default: ;
                endcase
                bip_next = bip_inc[1:0];
            end else begin
                blue_next  = held_reg[7:0];
                green_next = held_reg[15:8];
                red_next   = has_alpha_reg ? held_reg[23:16] : s_tdata;
                alpha_next = has_alpha_reg ? s_tdata : OPAQUE_ALPHA;
                bip_next   = 2'd0;
                held_next  = '0;
                if (rle_en_reg) begin
                    if (pkt_run_reg || pkt_rem_reg <= 8'd1) begin
                        pkt_rem_next    = 8'd0;
                        expect_hdr_next = 1'b1;
                    end else begin
                        pkt_rem_next = pkt_rem_reg - 8'd1;
                    end
                end
                cnt_next    = new_copies;
                adv_next    = new_copies;
                dest_x_next = rtl_reg ? width_reg - 16'd1 - col_reg : col_reg;
                dest_y_next = ttb_reg ? row_reg : height_reg - 16'd1 - row_reg;
                last_next   = 1'b0;
            end
        end

        if (cmd.walk_step) begin
            if (fits) begin
                col_next = col_reg + {8'd0, adv_reg};
                adv_next = 8'd0;
            end else if (last_row) begin
                // run reaches the end of the image: clamp to what was left
                done_next = 1'b1;
                last_next = 1'b1;
                cnt_next  = cnt_reg - left;
                adv_next  = 8'd0;
            end else begin
                row_next = row_reg + 16'd1;
                col_next = 16'd0;
                adv_next = left;
            end
        end

        if (cmd.load_out) begin
            out_valid_next = 1'b1;
            out_data_next  = {cnt_reg, dest_y_reg, dest_x_reg,
                              alpha_reg, blue_reg, green_reg, red_reg};
            out_last_next  = last_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_hdr_reg <= 1'b1;
            bip_reg        <= 2'd0;
            pkt_rem_reg    <= 8'd0;
            pkt_run_reg    <= 1'b0;
            held_reg       <= '0;
            col_reg        <= 16'd0;
            row_reg        <= 16'd0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            expect_hdr_reg <= expect_hdr_next;
            bip_reg        <= bip_next;
            pkt_rem_reg    <= pkt_rem_next;
            pkt_run_reg    <= pkt_run_next;
            held_reg       <= held_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            done_reg       <= done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        adv_reg      <= adv_next;
        cnt_reg      <= cnt_next;
        red_reg      <= red_next;
        green_reg    <= green_next;
        blue_reg     <= blue_next;
        alpha_reg    <= alpha_next;
        dest_x_reg   <= dest_x_next;
        dest_y_reg   <= dest_y_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- hdl/tga_rle_pixel_decoder.sv -----
// top level of the tga run-length pixel decoder
`timescale 1ns / 1ps
`default_nettype none

// Decodes the body bytes of a 24-bit or 32-bit TGA image, one byte per input item, into
// RGBA run records carrying the oriented destination of the first pixel, a copy count and
// an end-of-image flag on m_tlast. A byte that is a packet header or part of a pixel is
// taken in the idle state. The byte that completes a pixel starts a position walk over the
// image rows that the run's pixels cover, then the output register is loaded (this waits
// while that register still holds an untaken item); the walk advances across at most one row
// per cycle. Bytes are still taken while a record waits in the output register. Once the
// image is complete, further bytes are taken and dropped until reset. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
module tga_rle_pixel_decoder (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire  [trd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [trd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [trd_pkg::IN_TDATA_W-1:0]     s_tdata,   // data_byte
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // red, green, blue, alpha, dest_x, dest_y, copies
    output logic [trd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast    // image_last
);
    import trd_pkg::*;

    trd_cmd_t    cmd;
    trd_status_t status;

    trd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    trd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // no byte is taken while a run is being walked
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_step |-> !s_tready)
        else $error("byte accepted during position walk");

    // a record always paints at least one pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[71:64] != 8'd0)
        else $error("record with zero copies");

    // nothing follows the record that completes the image
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("record after end of image");

    // the output register is only loaded when it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("output record overwritten");

endmodule

`default_nettype wire
